>>> hdl/sadg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadg_pkg
// Shared widths, register indexes, types and divide constants for the
// screen-aware stepped frequency governor.
// ----------------------------------------------------------------------------
package sadg_pkg;

    localparam int PCT_W  = 7;
    localparam int FREQ_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = FREQ_W;

    // step and cap may exceed 24 bits (pct up to 127)
    localparam int SCALE_W = 25;
    localparam int PROD_W  = PCT_W + FREQ_W;          // 31
    localparam int QUART_W = PROD_W - 2;              // 29

    // floor(n / 25) = (n * DIV25_MAGIC) >> DIV25_SHIFT, exact for n < 2**29
    localparam int DIV25_SHIFT = 34;
    localparam int MAGIC_W = 30;
    localparam logic [MAGIC_W-1:0] DIV25_MAGIC = 30'd687194768;
    localparam int WIDE_W = QUART_W + MAGIC_W;        // 59

    localparam logic [PCT_W-1:0]  RST_UP_THR   = 7'd75;
    localparam logic [PCT_W-1:0]  RST_DOWN_THR = 7'd40;
    localparam logic [PCT_W-1:0]  RST_STEP_PCT = 7'd12;
    localparam logic [PCT_W-1:0]  RST_CAP_PCT  = 7'd40;
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ = '0;
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_THR   = 3'd0,
        CFG_DOWN_THR = 3'd1,
        CFG_STEP_PCT = 3'd2,
        CFG_CAP_PCT  = 3'd3,
        CFG_MIN_FREQ = 3'd4,
        CFG_MAX_FREQ = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PCT_W-1:0]   up_thr;
        logic [PCT_W-1:0]   down_thr;
        logic [FREQ_W-1:0]  min_freq;
        logic [FREQ_W-1:0]  max_freq;
        logic [SCALE_W-1:0] step;
        logic [SCALE_W-1:0] cap;
    } t_cfg;

endpackage

>>> hdl/screen_aware_stepped_dvfs_governor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_aware_stepped_dvfs_governor
// Stepped frequency governor top level: configuration block and tick pipeline.
// ----------------------------------------------------------------------------
// One sampling tick is accepted per clock while the input is not stalled; a tick
// that ramps or steps down presents its target frequency after passing the input,
// decision and result registers, a tick inside the hysteresis band gives nothing.
// The step and sleep cap are derived from the registers by a two-stage multiply
// and divide-by-100, so they follow a register write or reset through the product
// and scaled registers; the input stall is held high during reset. While a result
// waits, up to two more ticks are taken into the pipeline before the input stalls.
// ----------------------------------------------------------------------------
module screen_aware_stepped_dvfs_governor
    import sadg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PCT_W-1:0]      i_load_pct,
    input  logic [FREQ_W-1:0]     i_current_freq,
    input  logic                  i_screen_on,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FREQ_W-1:0]     o_target_freq,
    output logic                  o_round_down
);

    t_cfg w_cfg;

    sadg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    sadg_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_load_pct     (i_load_pct),
        .i_current_freq (i_current_freq),
        .i_screen_on    (i_screen_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_target_freq  (o_target_freq),
        .o_round_down   (o_round_down)
    );

endmodule

>>> hdl/sadg_pct_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadg_pct_scale
// Two-stage pct * full / 100: multiply, then divide by 100 as a shift by two
// and a reciprocal multiply by 1/25.
// ----------------------------------------------------------------------------
module sadg_pct_scale
    import sadg_pkg::*;
(
    input  logic               i_clk,
    input  logic [PCT_W-1:0]   i_pct,
    input  logic [FREQ_W-1:0]  i_full,
    output logic [SCALE_W-1:0] o_scaled
);

    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  n_prod;
    logic [SCALE_W-1:0] r_scaled;
    logic [SCALE_W-1:0] n_scaled;
    logic [WIDE_W-1:0]  w_wide;

    assign n_prod   = PROD_W'(i_pct) * PROD_W'(i_full);
    assign w_wide   = WIDE_W'(r_prod[PROD_W-1:2]) * WIDE_W'(DIV25_MAGIC);
    assign n_scaled = w_wide[DIV25_SHIFT +: SCALE_W];

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_scaled <= n_scaled;
    end

    assign o_scaled = r_scaled;

endmodule

>>> hdl/sadg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadg_cfg
// Configuration registers plus the derived step and sleep cap, which settle
// through the product and scaled registers of sadg_pct_scale after a write.
// ----------------------------------------------------------------------------
module sadg_cfg
    import sadg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    logic [PCT_W-1:0]   r_up_thr;
    logic [PCT_W-1:0]   r_down_thr;
    logic [PCT_W-1:0]   r_step_pct;
    logic [PCT_W-1:0]   r_cap_pct;
    logic [FREQ_W-1:0]  r_min_freq;
    logic [FREQ_W-1:0]  r_max_freq;
    logic [SCALE_W-1:0] w_step;
    logic [SCALE_W-1:0] w_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr   <= RST_UP_THR;
            r_down_thr <= RST_DOWN_THR;
            r_step_pct <= RST_STEP_PCT;
            r_cap_pct  <= RST_CAP_PCT;
            r_min_freq <= RST_MIN_FREQ;
            r_max_freq <= RST_MAX_FREQ;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_UP_THR:   r_up_thr   <= i_cfg_wdata[PCT_W-1:0];
                CFG_DOWN_THR: r_down_thr <= i_cfg_wdata[PCT_W-1:0];
                CFG_STEP_PCT: r_step_pct <= i_cfg_wdata[PCT_W-1:0];
                CFG_CAP_PCT:  r_cap_pct  <= i_cfg_wdata[PCT_W-1:0];
                CFG_MIN_FREQ: r_min_freq <= i_cfg_wdata[FREQ_W-1:0];
                CFG_MAX_FREQ: r_max_freq <= i_cfg_wdata[FREQ_W-1:0];
                default: ;
            endcase
        end
    end

    sadg_pct_scale u_step (
        .i_clk    (i_clk),
        .i_pct    (r_step_pct),
        .i_full   (r_max_freq),
        .o_scaled (w_step)
    );

    sadg_pct_scale u_cap (
        .i_clk    (i_clk),
        .i_pct    (r_cap_pct),
        .i_full   (r_max_freq),
        .o_scaled (w_cap)
    );

    always_comb begin
        o_cfg.up_thr   = r_up_thr;
        o_cfg.down_thr = r_down_thr;
        o_cfg.min_freq = r_min_freq;
        o_cfg.max_freq = r_max_freq;
        o_cfg.step     = w_step;
        o_cfg.cap      = w_cap;
    end

endmodule

>>> hdl/sadg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadg_core
// Tick pipeline: input register, decision register, then the request update
// that owns last_request and loads the result register.
// ----------------------------------------------------------------------------
module sadg_core
    import sadg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PCT_W-1:0]  i_load_pct,
    input  logic [FREQ_W-1:0] i_current_freq,
    input  logic              i_screen_on,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FREQ_W-1:0] o_target_freq,
    output logic              o_round_down
);

    // stage 1
    logic              r_s1_valid;
    logic [PCT_W-1:0]  r_s1_load;
    logic [FREQ_W-1:0] r_s1_cur;
    logic              r_s1_on;
    // stage 2
    logic              r_s2_valid;
    logic [FREQ_W-1:0] r_s2_cur;
    logic              r_s2_on;
    logic              r_s2_ramp;
    logic              r_s2_down;
    logic              n_s2_ramp;
    logic              n_s2_down;
    // state and result
    logic              r_primed;
    logic [FREQ_W-1:0] r_last;
    logic              r_out_valid;
    logic [FREQ_W-1:0] r_target;
    logic              r_round_down;

    logic out_free;
    logic s2_adv;
    logic s1_adv;
    logic fire;

    logic [FREQ_W-1:0]  base;
    logic [FREQ_W-1:0]  req;
    logic [FREQ_W+1:0]  sum;
    logic [FREQ_W-1:0]  up_res;
    logic [FREQ_W+1:0]  dstep;
    logic [FREQ_W-1:0]  dn_req;
    logic [SCALE_W-1:0] cap_f;
    logic [FREQ_W-1:0]  dn_res;
    logic [FREQ_W-1:0]  n_target;
    logic               has_res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_s2_valid && out_free;
    assign s2_adv     = !r_s2_valid || out_free;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign o_in_stall = !i_rst_n || !s1_adv;

    assign n_s2_ramp = r_s1_on && (r_s1_load > i_cfg.up_thr);
    assign n_s2_down = !n_s2_ramp && ((r_s1_load < i_cfg.down_thr) || !r_s1_on);

    always_comb begin
        base = r_primed ? r_last : r_s2_cur;
        req  = (base > i_cfg.max_freq || base < i_cfg.min_freq) ? r_s2_cur : base;

        // ramp up, saturate at max
        sum    = {2'b00, req} + {1'b0, i_cfg.step};
        up_res = (sum > {2'b00, i_cfg.max_freq}) ? i_cfg.max_freq : sum[FREQ_W-1:0];

        // step down, doubled while asleep
        dstep  = r_s2_on ? {1'b0, i_cfg.step} : {i_cfg.step, 1'b0};
        dn_req = ({2'b00, req} > dstep) ? FREQ_W'({2'b00, req} - dstep) : i_cfg.min_freq;
        cap_f  = (i_cfg.cap < {1'b0, i_cfg.min_freq}) ? {1'b0, i_cfg.min_freq} : i_cfg.cap;
        if (!r_s2_on) begin
            dn_res = ({1'b0, dn_req} > cap_f) ? cap_f[FREQ_W-1:0] : dn_req;
        end else begin
            dn_res = (dn_req < i_cfg.min_freq) ? i_cfg.min_freq : dn_req;
        end

        n_target = r_s2_ramp ? up_res : dn_res;
        has_res  = r_s2_ramp || r_s2_down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_primed    <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (fire) begin
                r_primed <= 1'b1;
                if (has_res) begin
                    r_last <= n_target;
                end else if (!r_primed) begin
                    r_last <= r_s2_cur;
                end
            end
            if (out_free) begin
                r_out_valid <= fire && has_res;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in_valid) begin
            r_s1_load <= i_load_pct;
            r_s1_cur  <= i_current_freq;
            r_s1_on   <= i_screen_on;
        end
        if (s2_adv && r_s1_valid) begin
            r_s2_cur  <= r_s1_cur;
            r_s2_on   <= r_s1_on;
            r_s2_ramp <= n_s2_ramp;
            r_s2_down <= n_s2_down;
        end
        if (fire && has_res) begin
            r_target     <= n_target;
            r_round_down <= r_s2_ramp;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target_freq = r_target;
    assign o_round_down  = r_round_down;

endmodule

>>> hdl/sadg_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadg_chk
// Port-level checks on the governor, bound to the top level.
// ----------------------------------------------------------------------------
module sadg_chk
    import sadg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [FREQ_W-1:0]     o_target_freq,
    input logic                  o_round_down
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_target_freq) && $stable(o_round_down))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |-> o_in_stall)
        else $error("input not stalled in reset");

    // input side only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output free");

endmodule

bind screen_aware_stepped_dvfs_governor sadg_chk u_sadg_chk (.*);

>>> tb/screen_aware_stepped_dvfs_governor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_aware_stepped_dvfs_governor_tb
// Self-checking bench for the stepped frequency governor. Sampling ticks are
// driven through the valid/stall port under several register settings, each
// accepted tick is fed to a predictor of the target frequency, and every
// request leaving the block is compared in order with the predicted one.
// ----------------------------------------------------------------------------

class freq_request_tracker;

    typedef struct {
        logic [sadg_pkg::FREQ_W-1:0] target;
        logic                        round_down;
    } freq_request_t;

    longint unsigned up_thr, down_thr, step_pct, cap_pct, min_f, max_f;
    logic [sadg_pkg::FREQ_W-1:0] last_req;
    bit              primed;
    freq_request_t   pending_requests[$];
    int              errors;

    function new();
        up_thr   = sadg_pkg::RST_UP_THR;
        down_thr = sadg_pkg::RST_DOWN_THR;
        step_pct = sadg_pkg::RST_STEP_PCT;
        cap_pct  = sadg_pkg::RST_CAP_PCT;
        min_f    = sadg_pkg::RST_MIN_FREQ;
        max_f    = sadg_pkg::RST_MAX_FREQ;
        last_req = '0;
        primed   = 1'b0;
        errors   = 0;
    endfunction

    function void set_reg(sadg_pkg::t_cfg_idx idx, logic [sadg_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            sadg_pkg::CFG_UP_THR:   up_thr   = val[sadg_pkg::PCT_W-1:0];
            sadg_pkg::CFG_DOWN_THR: down_thr = val[sadg_pkg::PCT_W-1:0];
            sadg_pkg::CFG_STEP_PCT: step_pct = val[sadg_pkg::PCT_W-1:0];
            sadg_pkg::CFG_CAP_PCT:  cap_pct  = val[sadg_pkg::PCT_W-1:0];
            sadg_pkg::CFG_MIN_FREQ: min_f    = val[sadg_pkg::FREQ_W-1:0];
            sadg_pkg::CFG_MAX_FREQ: max_f    = val[sadg_pkg::FREQ_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return pending_requests.size();
    endfunction

    function void note_tick(logic [sadg_pkg::PCT_W-1:0] load,
                            logic [sadg_pkg::FREQ_W-1:0] cur, logic awake);
        longint unsigned req, stp, cap;
        freq_request_t   exp_req;
        if (!primed) begin
            last_req = cur;
            primed   = 1'b1;
        end
        req = last_req;
        stp = (step_pct * max_f) / 100;
        // request outside the window: restart from the running frequency
        if (req > max_f || req < min_f) req = cur;
        if (awake && load > up_thr) begin
            req = req + stp;
            if (req > max_f) req = max_f;
            exp_req.round_down = 1'b1;
        end else if (load < down_thr || !awake) begin
            if (!awake) stp = stp * 2;
            if (req > stp) req = req - stp;
            else req = min_f;
            if (!awake) begin
                cap = (cap_pct * max_f) / 100;
                if (cap < min_f) cap = min_f;
                if (req > cap) req = cap;
            end else if (req < min_f) begin
                req = min_f;
            end
            exp_req.round_down = 1'b0;
        end else begin
            return;     // hysteresis band: nothing requested, state kept
        end
        exp_req.target = req[sadg_pkg::FREQ_W-1:0];
        last_req = exp_req.target;
        pending_requests.push_back(exp_req);
    endfunction

    function void check_request(logic [sadg_pkg::FREQ_W-1:0] target, logic round_down);
        freq_request_t exp_req;
        if (pending_requests.size() == 0) begin
            $display("%0t: unexpected request: target_freq %0d round_down %0b",
                     $time, target, round_down);
            errors++;
            return;
        end
        exp_req = pending_requests.pop_front();
        if (target !== exp_req.target) begin
            $display("%0t: target_freq mismatch: expected %0d, actual %0d",
                     $time, exp_req.target, target);
            errors++;
        end
        if (round_down !== exp_req.round_down) begin
            $display("%0t: round_down mismatch: expected %0b, actual %0b",
                     $time, exp_req.round_down, round_down);
            errors++;
        end
    endfunction

endclass

module screen_aware_stepped_dvfs_governor_tb;
    import sadg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PCT_W-1:0]      i_load_pct = '0;
    logic [FREQ_W-1:0]     i_current_freq = '0;
    logic                  i_screen_on = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [FREQ_W-1:0]     o_target_freq;
    logic                  o_round_down;

    freq_request_tracker model = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    bit screen_state = 1'b1;

    screen_aware_stepped_dvfs_governor DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_load_pct     (i_load_pct),
        .i_current_freq (i_current_freq),
        .i_screen_on    (i_screen_on),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_target_freq  (o_target_freq),
        .o_round_down   (o_round_down)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d requests still expected", $time, model.pending());
            $display("screen_aware_stepped_dvfs_governor_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            model.note_tick(i_load_pct, i_current_freq, i_screen_on);
        if (i_rst_n && o_out_valid && !i_out_stall)
            model.check_request(o_target_freq, o_round_down);
    end

    // result side: random stalls, plus a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= rx_idle_on && ($urandom_range(0, 99) < 9);
        end
    end

    task automatic send_tick(logic [PCT_W-1:0] load, logic [FREQ_W-1:0] cur, logic on);
        while (tx_idle_on && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_load_pct     <= load;
        i_current_freq <= cur;
        i_screen_on    <= on;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        model.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [PCT_W-1:0] up, logic [PCT_W-1:0] down,
                                  logic [PCT_W-1:0] stp, logic [PCT_W-1:0] cap,
                                  logic [FREQ_W-1:0] mn, logic [FREQ_W-1:0] mx);
        i_in_valid <= 1'b0;
        while (model.pending() != 0) @(negedge i_clk);
        // band ticks leave nothing to wait for, so cover the pipeline depth
        repeat (6) @(negedge i_clk);
        write_reg(CFG_UP_THR, up);
        write_reg(CFG_DOWN_THR, down);
        write_reg(CFG_STEP_PCT, stp);
        write_reg(CFG_CAP_PCT, cap);
        write_reg(CFG_MIN_FREQ, mn);
        write_reg(CFG_MAX_FREQ, mx);
        i_cfg_we <= 1'b0;
        // derived step and cap settle through the product and scaled registers after the last write
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [PCT_W-1:0] rand_pct();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 7'd100;
            2: return 7'd127;
            3: return 7'($urandom_range(101, 127));
            default: return 7'($urandom_range(1, 100));
        endcase
    endfunction

    task automatic random_settings(int phase);
        logic [FREQ_W-1:0] mn, mx;
        case (phase)
            0: apply_settings('0, '0, '0, '0, '0, '0);
            1: apply_settings(7'd127, 7'd127, 7'd127, 7'd127, '1, '1);
            2: apply_settings(rand_pct(), rand_pct(), rand_pct(), rand_pct(),
                              24'hC00000, 24'h400000);
            3: apply_settings(7'd100, 7'd1, 7'd100, 7'd1, '0, '1);
            default: begin
                mx = ($urandom_range(0, 3) == 0) ? '1 : FREQ_W'($urandom);
                if ($urandom_range(0, 7) == 0 && mx != '1)
                    mn = FREQ_W'($urandom_range(32'hFFFFFF, mx + 1));
                else
                    mn = FREQ_W'($urandom_range(mx / 2, 0));
                apply_settings(rand_pct(), rand_pct(), rand_pct(), rand_pct(), mn, mx);
            end
        endcase
    endtask

    task automatic run_ticks(int n);
        logic [PCT_W-1:0]  load;
        logic [FREQ_W-1:0] cur;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: load = 7'($urandom_range(101, 127));
                1: begin
                    case ($urandom_range(0, 3))
                        0: load = 7'(model.up_thr);
                        1: load = 7'(model.up_thr + 1);
                        2: load = 7'(model.down_thr - 1);
                        default: load = 7'(model.down_thr);
                    endcase
                end
                default: load = 7'($urandom_range(0, 100));
            endcase
            case ($urandom_range(0, 9))
                0: cur = $urandom_range(0, 1) ? '1 : '0;
                1, 2, 3, 4, 5, 6: begin
                    if (model.min_f <= model.max_f)
                        cur = FREQ_W'($urandom_range(32'(model.max_f), 32'(model.min_f)));
                    else
                        cur = FREQ_W'($urandom);
                end
                default: cur = FREQ_W'($urandom);
            endcase
            // screen state is sticky so ramps and decays can run their course
            if ($urandom_range(0, 9) == 0) screen_state = !screen_state;
            send_tick(load, cur, screen_state);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        // reset settings: first tick primes, then ramps, band, step-downs, sleep cap
        send_tick(7'd50, 24'd3000000, 1'b1);
        send_tick(7'd76, '0, 1'b1);
        send_tick(7'd75, '0, 1'b1);
        send_tick(7'd100, '1, 1'b1);
        send_tick(7'd127, '0, 1'b1);
        send_tick(7'd127, '0, 1'b1);
        send_tick(7'd40, '0, 1'b1);
        send_tick(7'd39, '0, 1'b1);
        send_tick(7'd0, '1, 1'b1);
        send_tick(7'd100, '0, 1'b0);
        repeat (4) send_tick(7'd0, '0, 1'b0);
        send_tick(7'd0, '0, 1'b1);

        // narrow window: reload from the running frequency, floor at min
        apply_settings(7'd60, 7'd30, 7'd20, 7'd100, 24'd2000000, 24'd8000000);
        send_tick(7'd80, 24'd9000000, 1'b1);
        send_tick(7'd20, 24'd1, 1'b1);
        send_tick(7'd45, 24'd5, 1'b1);
        send_tick(7'd0, '1, 1'b0);
        repeat (3) send_tick(7'd10, 24'd3000000, 1'b1);

        for (int phase = 0; phase < 10; phase++) begin
            random_settings(phase);
            if (phase == 4) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                run_ticks(150);
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end else if (phase == 6) begin
                // receiver holds off while ticks keep coming, filling the block
                tx_idle_on = 1'b0;
                hold_asks++;
                run_ticks(70);
                tx_idle_on = 1'b1;
            end else begin
                run_ticks(70);
            end
        end

        i_in_valid <= 1'b0;
        while (model.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (model.errors == 0)
            $display("screen_aware_stepped_dvfs_governor_tb passed");
        else
            $display("screen_aware_stepped_dvfs_governor_tb failed");
        $finish;
    end

endmodule
